>>> design/rtc_pkg.sv
// Shared types and constants for the roulette tour builder.
// No dependencies; used by rtc_serial_mul, roulette_tour_construction, rtc_tour_checker and tb_top.
package rtc_pkg;

  localparam int DEF_MAX_NODES = 64;
  localparam int DEF_COST_BITS = 16;

  localparam int FRAC_W       = 16;
  localparam int NODE_OUT_W   = 6;
  localparam int COST_OUT_W   = 22;
  localparam int NODE_COUNT_W = 7;
  localparam int APB_ADDR_W   = 3;

  localparam logic [COST_OUT_W-1:0]   COST_SAT       = 22'h3F_FFFF;
  localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_RST = 7'd64;
  localparam logic [FRAC_W-1:0]       ROUND_INIT     = 16'hFFFF;

  // register index, decoded from paddr[2]
  localparam logic REG_NODE_COUNT = 1'b0;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_START = 2'd1,
    OP_STEP  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [8:0] {
    S_IDLE      = 9'b0_0000_0001,
    S_SCAN1     = 9'b0_0000_0010,
    S_MUL1      = 9'b0_0000_0100,
    S_MUL2      = 9'b0_0000_1000,
    S_SCAN2     = 9'b0_0001_0000,
    S_UPDATE    = 9'b0_0010_0000,
    S_EMIT      = 9'b0_0100_0000,
    S_CLOSE_RD  = 9'b0_1000_0000,
    S_CLOSE_ADD = 9'b1_0000_0000
  } state_t;

  // request to the shared serial multiplier
  typedef struct packed {
    logic              start;
    logic              round;      // preload accumulator with ROUND_INIT
    logic [FRAC_W-1:0] multiplier;
  } mul_req_t;

endpackage

>>> design/rtc_serial_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on rtc_pkg (mul_req_t, FRAC_W, ROUND_INIT).
module rtc_serial_mul #(
  parameter int PROD_W = 48
) (
  input  logic                 clk,
  input  logic                 rst,
  input  rtc_pkg::mul_req_t    req,
  input  logic [PROD_W-1:0]    multiplicand,
  output logic                 done,
  output logic [PROD_W-1:0]    product
);

  localparam int CNT_W = $clog2(rtc_pkg::FRAC_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(rtc_pkg::FRAC_W - 1);

  logic [PROD_W-1:0]         a_sh;
  logic [rtc_pkg::FRAC_W-1:0] b_sh;
  logic [CNT_W-1:0]          cnt;
  logic                      busy;
  logic [PROD_W-1:0]         round_ext;

  assign round_ext = {{(PROD_W - rtc_pkg::FRAC_W){1'b0}}, rtc_pkg::ROUND_INIT};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        a_sh    <= multiplicand;
        b_sh    <= req.multiplier;
        product <= req.round ? round_ext : '0;
        cnt     <= '0;
        busy    <= 1'b1;
      end else if (busy) begin
        if (b_sh[0]) begin
          product <= product + a_sh;
        end
        a_sh <= a_sh << 1;
        b_sh <= b_sh >> 1;
        cnt  <= cnt + CNT_W'(1);
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> design/roulette_tour_construction.sv
// Roulette-wheel tour builder. Write, start and no-op beats are taken in idle and give no result.
// A step beat on a running tour makes two scans of the cost row through the
// single read port of the cost memory, plus two runs of the serial multiplier.
// A step with one node left skips the multiplier and second scan.
// Reset clears tour state, visited flags and node_count (to 64); cost memory is not cleared.
module roulette_tour_construction #(
  parameter int MAX_NODES = rtc_pkg::DEF_MAX_NODES,
  parameter int COST_BITS = rtc_pkg::DEF_COST_BITS
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // from_node[5:0], to_node[11:6], cost_value[27:12],
                                 // random_fraction[43:28], zero[47:44]
  input  logic [1:0]  s_tuser,   // opcode[1:0]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // node[5:0], tour_cost[27:6], zero[31:28]
  output logic        m_tlast,
  output logic [0:0]  m_tuser,   // status[0]
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [rtc_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int NODE_W = $clog2(MAX_NODES);
  localparam int ADDR_W = 2 * NODE_W;
  localparam int TOT_W  = COST_BITS + NODE_W;
  localparam int WSUM_W = TOT_W + NODE_W;
  localparam int TGT_W  = WSUM_W + rtc_pkg::FRAC_W;
  localparam int RC_W   = ((COST_BITS > rtc_pkg::COST_OUT_W) ? COST_BITS
                                                             : rtc_pkg::COST_OUT_W) + 1;
  localparam logic [NODE_W-1:0] LAST_J = NODE_W'(MAX_NODES - 1);
  localparam logic [8:0]        MAX9   = 9'(MAX_NODES);

  rtc_pkg::state_t state;

  // ---------------- input unpack ----------------
  rtc_pkg::op_t                 op;
  logic [NODE_W+5:0]            from_ext, to_ext;
  logic [COST_BITS+15:0]        cost_ext;
  logic [COST_BITS-1:0]         cost_in;
  logic [rtc_pkg::FRAC_W-1:0]   frac_in;
  logic                         in_acc;
  logic                         addr_ok;

  assign op       = rtc_pkg::op_t'(s_tuser);
  assign from_ext = {{NODE_W{1'b0}}, s_tdata[5:0]};
  assign to_ext   = {{NODE_W{1'b0}}, s_tdata[11:6]};
  assign cost_ext = {{COST_BITS{1'b0}}, s_tdata[27:12]};
  assign cost_in  = cost_ext[COST_BITS-1:0];
  assign frac_in  = s_tdata[43:28];
  assign s_tready = (state == rtc_pkg::S_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign addr_ok  = (from_ext < (NODE_W+6)'(MAX_NODES)) && (to_ext < (NODE_W+6)'(MAX_NODES));

  // ---------------- configuration ----------------
  logic [rtc_pkg::NODE_COUNT_W-1:0] node_count;
  logic                             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == rtc_pkg::REG_NODE_COUNT);
  assign prdata = (paddr[2] == rtc_pkg::REG_NODE_COUNT) ?
                  {{(32 - rtc_pkg::NODE_COUNT_W){1'b0}}, node_count} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= rtc_pkg::NODE_COUNT_RST;
    end else if (cfg_wr) begin
      node_count <= pwdata[rtc_pkg::NODE_COUNT_W-1:0];
    end
  end

  // ---------------- tour state ----------------
  logic [MAX_NODES-1:0] visited;
  logic [NODE_W-1:0]    current_node;
  logic [rtc_pkg::COST_OUT_W-1:0] running_cost;
  logic [NODE_W-1:0]    remaining;
  logic                 tour_active;

  // ---------------- cost memory ----------------
  logic [COST_BITS-1:0] cost_mem [2**ADDR_W];
  logic [COST_BITS-1:0] rd_data;
  logic [ADDR_W-1:0]    rd_addr, wr_addr;
  logic                 rd_en, mem_we;

  logic [NODE_W-1:0]    scan_j;
  logic                 issue_done;
  logic                 issuing;

  assign issuing = ((state == rtc_pkg::S_SCAN1) || (state == rtc_pkg::S_SCAN2)) && !issue_done;
  assign rd_en   = issuing || (state == rtc_pkg::S_CLOSE_RD);
  assign rd_addr = {current_node, (state == rtc_pkg::S_CLOSE_RD) ? NODE_W'(0) : scan_j};
  assign mem_we  = in_acc && (op == rtc_pkg::OP_WRITE) && addr_ok;
  assign wr_addr = {from_ext[NODE_W-1:0], to_ext[NODE_W-1:0]};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cost_mem[wr_addr] <= cost_in;
    end
    if (rd_en) begin
      rd_data <= cost_mem[rd_addr];
    end
  end

  // ---------------- scan datapath ----------------
  logic              rd_v, rd_last;
  logic [NODE_W-1:0] rd_j;
  logic              cand;

  logic [TOT_W-1:0]     tot, tot_next;
  logic                 first_found, first_found_next;
  logic [NODE_W-1:0]    first_node, first_node_next;
  logic [COST_BITS-1:0] first_cost, first_cost_next;
  logic [TOT_W-1:0]     w;
  logic [WSUM_W-1:0]    w_ext;
  logic [WSUM_W-1:0]    thr;
  logic                 hit;

  assign cand = rd_v && !visited[rd_j];
  assign w     = tot - {{NODE_W{1'b0}}, rd_data};
  assign w_ext = {{NODE_W{1'b0}}, w};
  assign hit   = cand && (w_ext >= thr);

  always_comb begin
    tot_next         = tot;
    first_found_next = first_found;
    first_node_next  = first_node;
    first_cost_next  = first_cost;
    if (cand) begin
      tot_next = tot + {{NODE_W{1'b0}}, rd_data};
      if (!first_found) begin
        first_found_next = 1'b1;
        first_node_next  = rd_j;
        first_cost_next  = rd_data;
      end
    end
  end

  // ---------------- shared multiplier ----------------
  rtc_pkg::mul_req_t mul_req;
  logic [TGT_W-1:0]  mul_a;
  logic              mul_done;
  logic [TGT_W-1:0]  mul_prod;
  logic [rtc_pkg::FRAC_W+NODE_W-1:0] rem_m1_ext;
  logic [NODE_W-1:0] rem_m1;
  logic [rtc_pkg::FRAC_W-1:0] frac;

  assign rem_m1     = remaining - NODE_W'(1);
  assign rem_m1_ext = {{rtc_pkg::FRAC_W{1'b0}}, rem_m1};

  rtc_serial_mul #(
    .PROD_W (TGT_W)
  ) u_mul (
    .clk          (clk),
    .rst          (rst),
    .req          (mul_req),
    .multiplicand (mul_a),
    .done         (mul_done),
    .product      (mul_prod)
  );

  // ---------------- saturating cost add ----------------
  logic [COST_BITS-1:0] chosen_cost;
  logic [NODE_W-1:0]    chosen;
  logic [COST_BITS-1:0] add_b;
  logic [RC_W-1:0]      rc_sum;
  logic [rtc_pkg::COST_OUT_W-1:0] rc_sat;

  assign add_b  = (state == rtc_pkg::S_CLOSE_ADD) ? rd_data : chosen_cost;
  assign rc_sum = {{(RC_W - rtc_pkg::COST_OUT_W){1'b0}}, running_cost}
                + {{(RC_W - COST_BITS){1'b0}}, add_b};
  assign rc_sat = (rc_sum > {{(RC_W - rtc_pkg::COST_OUT_W){1'b0}}, rtc_pkg::COST_SAT}) ?
                  rtc_pkg::COST_SAT : rc_sum[rtc_pkg::COST_OUT_W-1:0];

  // ---------------- start clamp ----------------
  logic [8:0] nc9, n9, rem9;

  assign nc9  = {2'b00, node_count};
  assign n9   = (nc9 < 9'd2) ? 9'd2 : ((nc9 > MAX9) ? MAX9 : nc9);
  assign rem9 = n9 - 9'd1;

  // ---------------- result staging and output ----------------
  logic [NODE_W-1:0]              res_node;
  logic [rtc_pkg::COST_OUT_W-1:0] res_cost;
  logic                           res_last, res_status, closing;
  logic [NODE_W+5:0]              res_node_ext;
  logic [rtc_pkg::NODE_OUT_W-1:0] out_node;
  logic [rtc_pkg::COST_OUT_W-1:0] out_cost;
  logic                           out_last, out_status;
  logic                           out_free;

  assign res_node_ext = {6'b0, res_node};
  assign out_free     = !m_tvalid || m_tready;
  assign m_tdata      = {4'b0, out_cost, out_node};
  assign m_tlast      = out_last;
  assign m_tuser      = out_status;

  // ---------------- control ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= rtc_pkg::S_IDLE;
      visited      <= '0;
      current_node <= '0;
      running_cost <= '0;
      remaining    <= '0;
      tour_active  <= 1'b0;
      m_tvalid     <= 1'b0;
      mul_req      <= '0;
      rd_v         <= 1'b0;
      issue_done   <= 1'b0;
    end else begin
      rd_v          <= issuing;
      rd_j          <= scan_j;
      rd_last       <= (scan_j == LAST_J);
      if (issuing) begin
        if (scan_j == LAST_J) begin
          issue_done <= 1'b1;
        end else begin
          scan_j <= scan_j + NODE_W'(1);
        end
      end
      // in S_EMIT the output register is reloaded instead
      if (m_tvalid && m_tready && (state != rtc_pkg::S_EMIT)) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        rtc_pkg::S_IDLE: begin
          if (in_acc) begin
            case (op)
              rtc_pkg::OP_START: begin
                for (int j = 0; j < MAX_NODES; j++) begin
                  visited[j] <= (j == 0) || (9'(j) >= n9);
                end
                current_node <= '0;
                running_cost <= '0;
                remaining    <= rem9[NODE_W-1:0];
                tour_active  <= 1'b1;
              end
              rtc_pkg::OP_STEP: begin
                if (!tour_active || (remaining == '0)) begin
                  res_node   <= '0;
                  res_cost   <= '0;
                  res_last   <= 1'b0;
                  res_status <= 1'b1;
                  closing    <= 1'b0;
                  state      <= rtc_pkg::S_EMIT;
                end else begin
                  frac        <= frac_in;
                  tot         <= '0;
                  first_found <= 1'b0;
                  first_node  <= '0;
                  first_cost  <= '0;
                  scan_j      <= '0;
                  issue_done  <= 1'b0;
                  state       <= rtc_pkg::S_SCAN1;
                end
              end
              default: ;
            endcase
          end
        end

        rtc_pkg::S_SCAN1: begin
          tot         <= tot_next;
          first_found <= first_found_next;
          first_node  <= first_node_next;
          first_cost  <= first_cost_next;
          if (rd_v && rd_last) begin
            if (remaining <= NODE_W'(1)) begin
              chosen      <= first_node_next;
              chosen_cost <= first_cost_next;
              state       <= rtc_pkg::S_UPDATE;
            end else begin
              // W = (candidates - 1) * tot
              mul_a              <= {{(TGT_W - TOT_W){1'b0}}, tot_next};
              mul_req.start      <= 1'b1;
              mul_req.round      <= 1'b0;
              mul_req.multiplier <= rem_m1_ext[rtc_pkg::FRAC_W-1:0];
              state              <= rtc_pkg::S_MUL1;
            end
          end
        end

        rtc_pkg::S_MUL1: begin
          if (mul_done) begin
            // threshold = ceil(r * W / 2^16)
            mul_a              <= mul_prod;
            mul_req.start      <= 1'b1;
            mul_req.round      <= 1'b1;
            mul_req.multiplier <= frac;
            state              <= rtc_pkg::S_MUL2;
          end else begin
            mul_req.start <= 1'b0;
          end
        end

        rtc_pkg::S_MUL2: begin
          mul_req.start <= 1'b0;
          if (mul_done) begin
            thr        <= mul_prod[TGT_W-1:rtc_pkg::FRAC_W];
            scan_j     <= '0;
            issue_done <= 1'b0;
            state      <= rtc_pkg::S_SCAN2;
          end
        end

        rtc_pkg::S_SCAN2: begin
          if (hit) begin
            chosen      <= rd_j;
            chosen_cost <= rd_data;
            state       <= rtc_pkg::S_UPDATE;
          end else begin
            if (cand) begin
              thr <= thr - w_ext;
            end
            if (rd_v && rd_last) begin
              chosen      <= first_node;
              chosen_cost <= first_cost;
              state       <= rtc_pkg::S_UPDATE;
            end
          end
        end

        rtc_pkg::S_UPDATE: begin
          running_cost    <= rc_sat;
          visited[chosen] <= 1'b1;
          current_node    <= chosen;
          remaining       <= remaining - NODE_W'(1);
          res_node        <= chosen;
          res_cost        <= rc_sat;
          res_last        <= 1'b0;
          res_status      <= 1'b0;
          closing         <= (remaining == NODE_W'(1));
          state           <= rtc_pkg::S_EMIT;
        end

        rtc_pkg::S_EMIT: begin
          if (out_free) begin
            m_tvalid   <= 1'b1;
            out_node   <= res_node_ext[rtc_pkg::NODE_OUT_W-1:0];
            out_cost   <= res_cost;
            out_last   <= res_last;
            out_status <= res_status;
            state      <= closing ? rtc_pkg::S_CLOSE_RD : rtc_pkg::S_IDLE;
          end
        end

        rtc_pkg::S_CLOSE_RD: begin
          state <= rtc_pkg::S_CLOSE_ADD;
        end

        rtc_pkg::S_CLOSE_ADD: begin
          // return leg to node 0
          running_cost <= rc_sat;
          current_node <= '0;
          tour_active  <= 1'b0;
          res_node     <= '0;
          res_cost     <= rc_sat;
          res_last     <= 1'b1;
          res_status   <= 1'b0;
          closing      <= 1'b0;
          state        <= rtc_pkg::S_EMIT;
        end

        default: state <= rtc_pkg::S_IDLE;
      endcase
    end
  end

  // ---------------- checks ----------------
  a_rem_needs_tour: assert property (@(posedge clk) disable iff (rst)
    (remaining != '0) |-> tour_active)
    else $error("nodes remain with no tour in progress");

  a_pick_unvisited: assert property (@(posedge clk) disable iff (rst)
    (state == rtc_pkg::S_UPDATE) |-> !visited[chosen])
    else $error("picked node already visited");

  a_count_match: assert property (@(posedge clk) disable iff (rst)
    ((state == rtc_pkg::S_IDLE) && tour_active) |-> ($countones(~visited) == remaining))
    else $error("unvisited count and remaining count disagree");

  a_mul_owner: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> ((state == rtc_pkg::S_MUL1) || (state == rtc_pkg::S_MUL2)))
    else $error("multiplier finished outside a multiply phase");

endmodule

>>> dv/rtc_tour_checker.sv
// Checker for roulette_tour_construction: snoops the input, result and register ports,
// predicts every result beat of the tour builder and compares it field by field.
// Depends on rtc_pkg only.
module rtc_tour_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [47:0] s_tdata,   // from_node[5:0], to_node[11:6], cost_value[27:12],
                                 // random_fraction[43:28], zero[47:44]
  input  logic [1:0]  s_tuser,   // opcode[1:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,   // node[5:0], tour_cost[27:6], zero[31:28]
  input  logic        m_tlast,
  input  logic [0:0]  m_tuser,   // status[0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [rtc_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  output int          outstanding,
  output int          fail_total,
  output int          hops_checked
);

  localparam int NODES = rtc_pkg::DEF_MAX_NODES;

  typedef struct packed {
    logic [rtc_pkg::NODE_OUT_W-1:0] node;
    logic [rtc_pkg::COST_OUT_W-1:0] cost;
    logic                           closing;
    logic                           status;
  } hop_t;

  logic [rtc_pkg::DEF_COST_BITS-1:0] cost_mem [NODES][NODES];
  logic [NODES-1:0]                  visited;
  logic [rtc_pkg::NODE_OUT_W-1:0]    cur_node;
  logic [rtc_pkg::COST_OUT_W-1:0]    run_cost;
  logic [rtc_pkg::NODE_COUNT_W-1:0]  nodes_left;
  logic                              tour_on;
  logic [rtc_pkg::NODE_COUNT_W-1:0]  node_count;
  hop_t                              expected_hops [$];
  int                                fail_count = 0;
  int                                hop_count = 0;

  function automatic void mismatch(string field, logic [31:0] want, logic [31:0] got);
    if (fail_count < 10)
      $display("[%0t] %s mismatch after %0d result beats: expected %0d, got %0d",
               $time, field, hop_count, want, got);
    fail_count++;
  endfunction

  function automatic logic [rtc_pkg::COST_OUT_W-1:0] add_sat(
      logic [rtc_pkg::COST_OUT_W-1:0] acc, logic [rtc_pkg::DEF_COST_BITS-1:0] c);
    logic [rtc_pkg::COST_OUT_W:0] s;
    s = {1'b0, acc} + (rtc_pkg::COST_OUT_W+1)'(c);
    return (s > {1'b0, rtc_pkg::COST_SAT}) ? rtc_pkg::COST_SAT
                                           : s[rtc_pkg::COST_OUT_W-1:0];
  endfunction

  // roulette draw over the unvisited nodes, weights are row total minus own cost
  function automatic logic [rtc_pkg::NODE_OUT_W-1:0] pick_next_node(
      logic [rtc_pkg::FRAC_W-1:0] frac);
    logic [63:0] row_sum;
    logic [63:0] weight_sum;
    logic [63:0] target;
    logic [63:0] prefix;
    int first;
    row_sum = 0;
    weight_sum = 0;
    prefix = 0;
    first = -1;
    for (int j = 0; j < NODES; j++) begin
      if (!visited[j]) begin
        if (first < 0) first = j;
        row_sum += 64'(cost_mem[cur_node][j]);
      end
    end
    if (first < 0) return '0;
    if (nodes_left <= 1) return rtc_pkg::NODE_OUT_W'(first);
    for (int j = 0; j < NODES; j++)
      if (!visited[j]) weight_sum += row_sum - 64'(cost_mem[cur_node][j]);
    target = 64'(frac) * weight_sum;
    if (target == 0) return rtc_pkg::NODE_OUT_W'(first);
    for (int j = 0; j < NODES; j++) begin
      if (!visited[j]) begin
        prefix += row_sum - 64'(cost_mem[cur_node][j]);
        if ((prefix << 16) >= target) return rtc_pkg::NODE_OUT_W'(j);
      end
    end
    return rtc_pkg::NODE_OUT_W'(first);
  endfunction

  task automatic apply_beat(rtc_pkg::op_t op, logic [5:0] row, logic [5:0] col,
                            logic [15:0] cost, logic [15:0] frac);
    logic [rtc_pkg::NODE_OUT_W-1:0] chosen;
    hop_t                           h;
    int                             n;
    case (op)
      rtc_pkg::OP_WRITE: cost_mem[row][col] = cost[rtc_pkg::DEF_COST_BITS-1:0];
      rtc_pkg::OP_START: begin
        n = node_count;
        if (n < 2) n = 2;
        if (n > NODES) n = NODES;
        for (int j = 0; j < NODES; j++) visited[j] = (j == 0) || (j >= n);
        cur_node = '0;
        run_cost = '0;
        nodes_left = rtc_pkg::NODE_COUNT_W'(n - 1);
        tour_on = 1'b1;
      end
      rtc_pkg::OP_STEP: begin
        if (!tour_on || nodes_left == 0) begin
          h = '{node: '0, cost: '0, closing: 1'b0, status: 1'b1};
          expected_hops.insert(expected_hops.size(), h);
        end else begin
          chosen = pick_next_node(frac);
          run_cost = add_sat(run_cost, cost_mem[cur_node][chosen]);
          visited[chosen] = 1'b1;
          cur_node = chosen;
          nodes_left--;
          h = '{node: chosen, cost: run_cost, closing: 1'b0, status: 1'b0};
          expected_hops.insert(expected_hops.size(), h);
          if (nodes_left == 0) begin
            // last node taken: the return leg to node 0 follows in its own beat
            run_cost = add_sat(run_cost, cost_mem[cur_node][0]);
            cur_node = '0;
            tour_on = 1'b0;
            h = '{node: '0, cost: run_cost, closing: 1'b1, status: 1'b0};
            expected_hops.insert(expected_hops.size(), h);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_hop(hop_t got);
    hop_t want;
    if (expected_hops.size() == 0) begin
      mismatch("unexpected result beat, node", '0, 32'(got.node));
      return;
    end
    want = expected_hops.pop_front();
    hop_count++;
    if (got.node != want.node) mismatch("node", 32'(want.node), 32'(got.node));
    if (got.cost != want.cost) mismatch("tour_cost", 32'(want.cost), 32'(got.cost));
    if (got.closing != want.closing)
      mismatch("last", 32'(want.closing), 32'(got.closing));
    if (got.status != want.status)
      mismatch("status", 32'(want.status), 32'(got.status));
  endtask

  always @(posedge clk) begin : monitor
    hop_t seen;
    if (rst) begin
      visited = '0;
      cur_node = '0;
      run_cost = '0;
      nodes_left = '0;
      tour_on = 1'b0;
      node_count = rtc_pkg::NODE_COUNT_RST;
      expected_hops.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite && paddr[2] == rtc_pkg::REG_NODE_COUNT)
          node_count = pwdata[rtc_pkg::NODE_COUNT_W-1:0];
        else if (!pwrite && prdata[rtc_pkg::NODE_COUNT_W-1:0] != node_count)
          mismatch("node_count readback", 32'(node_count),
                   32'(prdata[rtc_pkg::NODE_COUNT_W-1:0]));
      end
      if (s_tvalid && s_tready)
        apply_beat(rtc_pkg::op_t'(s_tuser), s_tdata[5:0], s_tdata[11:6], s_tdata[27:12],
                   s_tdata[43:28]);
      if (m_tvalid && m_tready) begin
        seen = '{node: m_tdata[5:0], cost: m_tdata[27:6], closing: m_tlast,
                 status: m_tuser[0]};
        check_hop(seen);
      end
    end
    outstanding  <= expected_hops.size();
    fail_total   <= fail_count;
    hops_checked <= hop_count;
  end

endmodule

>>> dv/tb_top.sv
// Top of the roulette_tour_construction testbench: clock, reset, stimulus, back-pressure
// and the verdict. Depends on rtc_pkg, the block and rtc_tour_checker.
module tb_top;

  localparam int ITEMS_TOTAL   = 1950;
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int SETTLE_CYCLES = 200;
  localparam int HOLD_CYCLES   = 3000;
  localparam int NODES         = rtc_pkg::DEF_MAX_NODES;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;   // from_node[5:0], to_node[11:6], cost_value[27:12],
                               // random_fraction[43:28], zero[47:44]
  logic [1:0]  s_tuser = '0;   // opcode[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // node[5:0], tour_cost[27:6], zero[31:28]
  logic        m_tlast;
  logic [0:0]  m_tuser;        // status[0]
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [rtc_pkg::APB_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          outstanding;
  int          fail_total;
  int          hops_checked;

  bit [NODES-1:0] cost_known [NODES];
  int n_live = NODES;          // clamped node count the next start will use
  int steps_left = 0;          // steps still owed to the running tour
  int items_sent = 0;
  int steps_sent = 0;
  int settings = 0;
  int cycle_count = 0;
  bit idle_on = 1'b0;
  bit hold_req = 1'b0;

  roulette_tour_construction dut (.*);
  rtc_tour_checker tour_check (.*);

  initial forever #6 clk = ~clk;

  function automatic logic [15:0] rand_cost();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_frac();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_beat(rtc_pkg::op_t op, logic [5:0] row = '0, logic [5:0] col = '0,
                           logic [15:0] cost = '0, logic [15:0] frac = '0);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {4'b0, frac, cost, col, row};
    do @(posedge clk); while (!s_tready);
    items_sent++;
    case (op)
      rtc_pkg::OP_WRITE: cost_known[row][col] = 1'b1;
      rtc_pkg::OP_START: steps_left = n_live - 1;
      rtc_pkg::OP_STEP: begin
        steps_sent++;
        if (steps_left > 0) steps_left--;
      end
      default: ;
    endcase
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // write node_count once the block is quiet, then read it straight back
  task automatic set_node_count(logic [rtc_pkg::NODE_COUNT_W-1:0] value);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {rtc_pkg::REG_NODE_COUNT, 2'b00};
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    n_live = (value < 2) ? 2 : (value > NODES) ? NODES : value;
    settings++;
  endtask

  // every entry a tour over n nodes can read gets a value first (only row 0 when row0_only is set)
  task automatic fill_costs(int n, bit row0_only);
    for (int a = 0; a < n; a++)
      for (int b = 0; b < n; b++)
        if (a != b && !cost_known[a][b] && (!row0_only || a == 0))
          send_beat(rtc_pkg::OP_WRITE, 6'(a), 6'(b), rand_cost());
  endtask

  task automatic run_tour();
    send_beat(rtc_pkg::OP_START);
    while (steps_left > 0) begin
      case ($urandom_range(0, 15))
        0: send_beat(rtc_pkg::OP_WRITE, 6'($urandom_range(0, n_live - 1)),
                     6'($urandom_range(0, n_live - 1)), rand_cost());
        1: send_beat(rtc_pkg::OP_WRITE, 6'($urandom), 6'($urandom), 16'($urandom));
        2: send_beat(rtc_pkg::OP_NOP, 6'($urandom), 6'($urandom), 16'($urandom),
                     16'($urandom));
        3: send_beat(rtc_pkg::OP_START);
        default: ;
      endcase
      send_beat(rtc_pkg::OP_STEP, 6'($urandom), 6'($urandom), 16'($urandom), rand_frac());
    end
    // stray step once the tour has closed
    if ($urandom_range(0, 3) == 0)
      send_beat(rtc_pkg::OP_STEP, 6'($urandom), 6'($urandom), 16'($urandom), rand_frac());
  endtask

  initial begin : stimulus
    logic [rtc_pkg::NODE_COUNT_W-1:0] value;
    bit hold_done;
    hold_done = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // no tour yet: a step is an error, opcode 3 gives nothing
    send_beat(rtc_pkg::OP_STEP, 6'h3F, 6'h3F, 16'hFFFF, 16'hFFFF);
    send_beat(rtc_pkg::OP_NOP, 6'h3F, 6'h3F, 16'hFFFF, 16'hFFFF);
    send_beat(rtc_pkg::OP_WRITE, 6'h3F, 6'h3F, 16'hFFFF);
    // count below range clamps to two nodes; the single candidate needs no draw
    set_node_count(7'd0);
    send_beat(rtc_pkg::OP_WRITE, 6'd0, 6'd1, 16'hFFFF);
    send_beat(rtc_pkg::OP_WRITE, 6'd1, 6'd0, 16'hFFFF);
    send_beat(rtc_pkg::OP_START);
    send_beat(rtc_pkg::OP_STEP, '0, '0, '0, 16'h8000);
    send_beat(rtc_pkg::OP_STEP, '0, '0, '0, 16'h8000);
    set_node_count(7'd3);
    fill_costs(3, 1'b0);
    send_beat(rtc_pkg::OP_START);
    send_beat(rtc_pkg::OP_STEP);                                 // zero fraction
    send_beat(rtc_pkg::OP_WRITE, 6'd1, 6'd2, 16'd0);             // rewrite mid-tour
    send_beat(rtc_pkg::OP_WRITE, 6'd2, 6'd1, 16'd0);
    send_beat(rtc_pkg::OP_START);                                // restart mid-tour
    send_beat(rtc_pkg::OP_STEP, '0, '0, '0, 16'hFFFF);
    send_beat(rtc_pkg::OP_STEP, '0, '0, '0, 16'hFFFF);
    // all weights zero: draw target is zero
    send_beat(rtc_pkg::OP_WRITE, 6'd0, 6'd1, 16'd0);
    send_beat(rtc_pkg::OP_WRITE, 6'd0, 6'd2, 16'd0);
    send_beat(rtc_pkg::OP_START);
    send_beat(rtc_pkg::OP_STEP, '0, '0, '0, 16'hFFFF);
    send_beat(rtc_pkg::OP_STEP, '0, '0, '0, 16'hFFFF);

    while (items_sent < ITEMS_TOTAL) begin
      case ($urandom_range(0, 9))
        0: value = $urandom_range(0, 1) ? 7'd64 : 7'($urandom_range(65, 127));
        1: value = 7'($urandom_range(0, 1));
        default: value = 7'($urandom_range(2, 10));
      endcase
      set_node_count(value);
      idle_on = (items_sent < ITEMS_TOTAL * 7 / 8) && ($urandom_range(0, 3) != 0);
      if (!hold_done && items_sent > ITEMS_TOTAL / 3 && n_live <= 10) begin
        hold_req = 1'b1;
        hold_done = 1'b1;
      end
      if (n_live == NODES) begin
        // only row 0 is loaded at full size, so each tour gets one step before restart
        fill_costs(NODES, 1'b1);
        repeat ($urandom_range(2, 5)) begin
          send_beat(rtc_pkg::OP_START);
          if ($urandom_range(0, 1))
            send_beat(rtc_pkg::OP_WRITE, 6'd0, 6'($urandom_range(1, NODES - 1)),
                      rand_cost());
          send_beat(rtc_pkg::OP_STEP, 6'($urandom), 6'($urandom), 16'($urandom),
                    rand_frac());
        end
      end else begin
        fill_costs(n_live, 1'b0);
        repeat ($urandom_range(2, 5)) run_tour();
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d input beats (%0d steps) over %0d node_count settings",
             items_sent, steps_sent, settings);
    $display("%0d result beats compared, %0d mismatches", hops_checked, fail_total);
    if (fail_total == 0 && outstanding == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin : sink
    do @(posedge clk); while (rst);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results still owed", cycle_count, outstanding);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
